// ===== rtl/rle_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the run-length decimal codec.
// No dependencies; imported by every module of the block.
package rle_pkg;

	// Widths fixed by the byte stream and the run counters
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 7;
	localparam int STAT_W = 2;

	// Default run cap (valid range 1 to 99)
	localparam int MAX_RUN_DEF = 64;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_CLIP = 2'd1;
	localparam logic [STAT_W-1:0] STAT_END  = 2'd2;

	// Codec direction
	localparam logic MODE_COMPRESS   = 1'b0;
	localparam logic MODE_DECOMPRESS = 1'b1;

	localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

	// Number of result kinds, one pending flag each
	localparam int NUM_KIND = 8;

	// Sequencer states; each busy state emits one kind of result
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_TENS,
		ST_A_ONES,
		ST_A_BYTE,
		ST_B_TENS,
		ST_B_ONES,
		ST_B_BYTE,
		ST_REP,
		ST_END
	} state_t;

	typedef logic [NUM_KIND-1:0] kind_flags_t;

	// Controller to datapath
	typedef struct packed {
		logic   accept;
		logic   emit;
		state_t emit_sel;
		logic   emit_last;
	} rle_cmd_t;

	// Datapath to controller
	typedef struct packed {
		kind_flags_t plan;
		kind_flags_t pend;
		logic        rep_more;
		logic        out_free;
		logic        last;
	} rle_sts_t;

	// Pending result kinds for two flushed runs, a repeat and an end marker
	function automatic kind_flags_t kind_flags(
		input logic [LEN_W-1:0] a_len,
		input logic [LEN_W-1:0] b_len,
		input logic [LEN_W-1:0] rep_cnt,
		input logic             end_mark
	);
		kind_flags_t f;
		f[0] = (a_len >= LEN_W'(10));
		f[1] = (a_len >= LEN_W'(2));
		f[2] = (a_len != '0);
		f[3] = (b_len >= LEN_W'(10));
		f[4] = (b_len >= LEN_W'(2));
		f[5] = (b_len != '0);
		f[6] = (rep_cnt != '0);
		f[7] = end_mark;
		return f;
	endfunction

	// First pending kind in emission order
	function automatic state_t pick_state(input kind_flags_t f);
		state_t s;
		priority if (f[0]) s = ST_A_TENS;
		else if (f[1])     s = ST_A_ONES;
		else if (f[2])     s = ST_A_BYTE;
		else if (f[3])     s = ST_B_TENS;
		else if (f[4])     s = ST_B_ONES;
		else if (f[5])     s = ST_B_BYTE;
		else if (f[6])     s = ST_REP;
		else if (f[7])     s = ST_END;
		else               s = ST_IDLE;
		return s;
	endfunction

	// Kinds still to come after the given state
	function automatic kind_flags_t later_mask(input state_t s);
		kind_flags_t m;
		unique case (s)
			ST_A_TENS: m = 8'b1111_1110;
			ST_A_ONES: m = 8'b1111_1100;
			ST_A_BYTE: m = 8'b1111_1000;
			ST_B_TENS: m = 8'b1111_0000;
			ST_B_ONES: m = 8'b1110_0000;
			ST_B_BYTE: m = 8'b1100_0000;
			ST_REP:    m = 8'b1000_0000;
			default:   m = 8'b0000_0000;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/rle_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the codec's byte stream and results.
// Depends on rle_pkg for field widths.
interface rle_in_if import rle_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface rle_out_if import rle_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              out_last;
	logic [STAT_W-1:0] out_status;

	modport source (output valid, output out_byte, output out_last, output out_status,
		input ready);
	modport sink   (input valid, input out_byte, input out_last, input out_status,
		output ready);
endinterface

// ===== rtl/rle_decimal_codec.sv =====
`timescale 1ns / 1ps
// Top level of the run-length codec with decimal counts.
// Depends on rle_pkg, rle_ifs, rle_ctrl and rle_datapath.
//
// Usage:
//  feed   : valid/ready sink of input bytes (in_byte, in_last marks end of string).
//  result : valid/ready source of result bytes (out_byte, out_last, out_status).
//  cfg_we / cfg_wdata : writes the mode bit (0 compress, 1 decompress) and clears
//           all run and count state; write only while no transaction is in flight.
//  A transaction is accepted only while the sequencer is idle. A byte that
//  yields no result leaves the sequencer idle. Otherwise each result is loaded
//  into the output register, and the next input is taken once the last result
//  is loaded. A transaction yields N results (N up to 4 in compress, up to
//  MAX_RUN in decompress), loaded one per cycle while the receiver keeps up.
//  The first result passes the sequencer state and then the output register;
//  a stalled receiver holds the output register and freezes the sequencer, and
//  no result is dropped.
//  Reset (arst_n low) selects compress mode, clears all stream state and
//  empties the output register.
module rle_decimal_codec import rle_pkg::*; #(
	parameter int MAX_RUN = MAX_RUN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rle_in_if.sink    feed,
	rle_out_if.source result,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	rle_cmd_t cmd;
	rle_sts_t sts;

	// Sequencer
	rle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (feed.valid),
		.in_ready (feed.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Stream state and output register
	rle_datapath #(
		.MAX_RUN (MAX_RUN)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_byte    (feed.in_byte),
		.in_last    (feed.in_last),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_byte   (result.out_byte),
		.out_last   (result.out_last),
		.out_status (result.out_status)
	);

endmodule

// ===== rtl/rle_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: stream state, per-transaction result plan, digit split, output register.
// Depends on rle_pkg; driven by rle_ctrl through rle_cmd_t.
module rle_datapath import rle_pkg::*; #(
	parameter int MAX_RUN = MAX_RUN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              in_last,
	input  rle_cmd_t          cmd,
	output rle_sts_t          sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_last,
	output logic [STAT_W-1:0] out_status
);

	localparam logic [LEN_W-1:0] CAP    = LEN_W'(MAX_RUN);
	localparam logic [9:0]       CAP_10 = 10'(MAX_RUN);

	// Stream state
	logic              mode_q;
	logic [BYTE_W-1:0] run_value_q;
	logic [LEN_W-1:0]  run_length_q;
	logic [LEN_W-1:0]  count_accum_q;
	logic              digits_seen_q;
	logic              count_clipped_q;

	// Plan of the transaction in progress
	logic [BYTE_W-1:0] a_val_q, b_val_q, rep_byte_q;
	logic [LEN_W-1:0]  a_len_q, b_len_q, rep_cnt_q;
	logic              rep_clip_q, end_q, last_q;

	// Output register
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic [STAT_W-1:0] out_status_q;

	// Next values for an accepted transaction
	logic [BYTE_W-1:0] a_val_n, b_val_n, rep_byte_n, run_value_n;
	logic [LEN_W-1:0]  a_len_n, b_len_n, rep_cnt_n, run_length_n, count_accum_n;
	logic              rep_clip_n, end_n, digits_seen_n, count_clipped_n;

	// Compress terms
	logic              flush_a;
	logic [LEN_W-1:0]  new_len;
	logic              flush_b;

	// Decompress terms
	logic              is_digit;
	logic [LEN_W-1:0]  acc_base;
	logic [9:0]        acc_10;
	logic [LEN_W-1:0]  times;

	// Digit split
	logic [LEN_W-1:0]  split_len;
	logic [14:0]       split_prod;
	logic [3:0]        tens;
	logic [LEN_W-1:0]  ones_full;

	logic [BYTE_W-1:0] item_byte;
	logic [STAT_W-1:0] item_status;

	// Compress: flush the old run on a change, then the new run at the cap or at the end
	always_comb begin
		flush_a = (run_length_q != '0) && ((in_byte != run_value_q) || (run_length_q >= CAP));
		new_len = ((run_length_q == '0) || flush_a) ? LEN_W'(1) : run_length_q + LEN_W'(1);
		flush_b = (new_len >= CAP) || in_last;
	end

	// Decompress: decimal accumulate with saturation
	always_comb begin
		is_digit = (in_byte >= ASCII_ZERO) && (in_byte <= ASCII_NINE);
		acc_base = digits_seen_q ? count_accum_q : '0;
		acc_10   = {acc_base, 3'b000} + {2'b00, acc_base, 1'b0} + {6'b0, in_byte[3:0]};
		times    = digits_seen_q ? count_accum_q : LEN_W'(1);
	end

	// Next state and result plan
	always_comb begin
		run_value_n     = run_value_q;
		run_length_n    = run_length_q;
		count_accum_n   = count_accum_q;
		digits_seen_n   = digits_seen_q;
		count_clipped_n = count_clipped_q;
		a_val_n         = run_value_q;
		a_len_n         = '0;
		b_val_n         = in_byte;
		b_len_n         = '0;
		rep_byte_n      = in_byte;
		rep_cnt_n       = '0;
		rep_clip_n      = count_clipped_q;
		end_n           = 1'b0;
		if (mode_q == MODE_COMPRESS) begin
			a_len_n      = flush_a ? run_length_q : '0;
			run_value_n  = ((run_length_q == '0) || flush_a) ? in_byte : run_value_q;
			b_val_n      = run_value_n;
			b_len_n      = flush_b ? new_len : '0;
			run_length_n = flush_b ? '0 : new_len;
		end else begin
			if (is_digit) begin
				if (acc_10 > CAP_10) begin
					count_accum_n   = CAP;
					count_clipped_n = 1'b1;
				end else begin
					count_accum_n = acc_10[LEN_W-1:0];
				end
				digits_seen_n = 1'b1;
			end else begin
				rep_cnt_n       = times;
				count_accum_n   = '0;
				digits_seen_n   = 1'b0;
				count_clipped_n = 1'b0;
			end
			if (in_last) begin
				end_n           = is_digit || (times == '0);
				count_accum_n   = '0;
				digits_seen_n   = 1'b0;
				count_clipped_n = 1'b0;
			end
		end
	end

	// Stream state and plan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_COMPRESS;
			run_value_q     <= '0;
			run_length_q    <= '0;
			count_accum_q   <= '0;
			digits_seen_q   <= 1'b0;
			count_clipped_q <= 1'b0;
			a_len_q         <= '0;
			b_len_q         <= '0;
			rep_cnt_q       <= '0;
			end_q           <= 1'b0;
			last_q          <= 1'b0;
		end else if (cfg_we) begin
			mode_q          <= cfg_wdata;
			run_value_q     <= '0;
			run_length_q    <= '0;
			count_accum_q   <= '0;
			digits_seen_q   <= 1'b0;
			count_clipped_q <= 1'b0;
		end else if (cmd.accept) begin
			run_value_q     <= run_value_n;
			run_length_q    <= run_length_n;
			count_accum_q   <= count_accum_n;
			digits_seen_q   <= digits_seen_n;
			count_clipped_q <= count_clipped_n;
			a_len_q         <= a_len_n;
			b_len_q         <= b_len_n;
			rep_cnt_q       <= rep_cnt_n;
			end_q           <= end_n;
			last_q          <= in_last;
		end else if (cmd.emit && (cmd.emit_sel == ST_REP)) begin
			rep_cnt_q <= rep_cnt_q - LEN_W'(1);
		end
	end

	// Plan payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			a_val_q    <= a_val_n;
			b_val_q    <= b_val_n;
			rep_byte_q <= rep_byte_n;
			rep_clip_q <= rep_clip_n;
		end
	end

	// Decimal split of a run length: tens by reciprocal multiply
	always_comb begin
		split_len  = ((cmd.emit_sel == ST_A_TENS) || (cmd.emit_sel == ST_A_ONES)) ?
			a_len_q : b_len_q;
		split_prod = 15'(split_len) * 15'd205;
		tens       = split_prod[14:11];
		ones_full  = split_len - {tens[3:0], 3'b000} - {2'b00, tens[3:0], 1'b0};
	end

	// Result selection
	always_comb begin
		item_byte   = '0;
		item_status = STAT_OK;
		unique case (cmd.emit_sel)
			ST_A_TENS, ST_B_TENS: item_byte = ASCII_ZERO + {4'b0000, tens};
			ST_A_ONES, ST_B_ONES: item_byte = ASCII_ZERO + {4'b0000, ones_full[3:0]};
			ST_A_BYTE:            item_byte = a_val_q;
			ST_B_BYTE:            item_byte = b_val_q;
			ST_REP: begin
				item_byte   = rep_byte_q;
				item_status = rep_clip_q ? STAT_CLIP : STAT_OK;
			end
			ST_END:               item_status = STAT_END;
			default:              item_byte = '0;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q   <= item_byte;
			out_last_q   <= cmd.emit_last;
			out_status_q <= item_status;
		end
	end

	// Status to the controller
	always_comb begin
		sts.plan     = kind_flags(a_len_n, b_len_n, rep_cnt_n, end_n);
		sts.pend     = kind_flags(a_len_q, b_len_q, rep_cnt_q, end_q);
		sts.rep_more = (rep_cnt_q > LEN_W'(1));
		sts.out_free = !out_valid_q || out_ready;
		sts.last     = last_q;
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign out_last   = out_last_q;
	assign out_status = out_status_q;

endmodule

// ===== rtl/rle_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences the results of one transaction, one per cycle when free.
// Depends on rle_pkg; commands rle_datapath through rle_cmd_t.
module rle_ctrl import rle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rle_sts_t sts,
	output rle_cmd_t cmd
);

	state_t state_q, state_d;
	state_t after_emit;
	logic   can_emit;

	// Where the sequence goes once the current result is out
	always_comb begin
		if ((state_q == ST_REP) && sts.rep_more) begin
			after_emit = ST_REP;
		end else begin
			after_emit = pick_state(sts.pend & later_mask(state_q));
		end
		can_emit = (state_q != ST_IDLE) && sts.out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		if (state_q == ST_IDLE) begin
			if (in_valid) begin
				state_d = pick_state(sts.plan);
			end
		end else if (can_emit) begin
			state_d = after_emit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Outputs
	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		cmd.accept    = in_valid && (state_q == ST_IDLE);
		cmd.emit      = can_emit;
		cmd.emit_sel  = state_q;
		cmd.emit_last = sts.last && (after_emit == ST_IDLE);
	end

endmodule
